// ----- sv/se2x_pkg.sv -----
package se2x_pkg;

  // rotation clamp in q3.13, just over pi
  localparam logic signed [15:0] RotLimit = 16'sd25736;
  // number of horner cells per series
  localparam int NumTerms = 11;
  // one in q2.30
  localparam logic signed [31:0] Q30One = 32'sh4000_0000;

  // item handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic signed [15:0] rot;
    logic [29:0]        x2;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] ra;   // sin(w)/w partial, q2.30
    logic signed [31:0] rc;   // 2(1-cos w)/w^2 partial, q2.30
  } se2x_item_t;

  // finished transform
  typedef struct packed {
    logic signed [15:0] cos_term;
    logic signed [15:0] sin_term;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic               overflow;
  } se2x_res_t;

endpackage

// ----- sv/se2x_if.sv -----
interface se2x_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rotation;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;

  modport source (output valid, rotation, vel_x, vel_y, input ready);
  modport sink   (input valid, rotation, vel_x, vel_y, output ready);
endinterface

interface se2x_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cos_term;
  logic signed [15:0] sin_term;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;
  logic               overflow;

  modport source (output valid, cos_term, sin_term, shift_x, shift_y, overflow, input ready);
  modport sink   (input valid, cos_term, sin_term, shift_x, shift_y, overflow, output ready);
endinterface

// ----- sv/se2x_cell.sv -----
module se2x_cell #(
  parameter int K = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  se2x_pkg::se2x_item_t item_i,
  output se2x_pkg::se2x_item_t item_o
);
  import se2x_pkg::*;

  // lane 0: sin series, lane 1: cosine series
  localparam int DA = (2 * K) * (2 * K + 1);
  localparam int DC = (2 * K + 1) * (2 * K + 2);
  localparam logic [33:0] MA = 34'((64'd1 << 35) / DA);
  localparam logic [33:0] MC = 34'((64'd1 << 35) / DC);
  localparam logic [9:0]  DV [2] = '{10'(DA), 10'(DC)};
  localparam logic [33:0] MV [2] = '{MA, MC};

  se2x_item_t  it1_q, it2_q, it3_q, it4_q;
  se2x_item_t  it4_d;
  logic [1:0]  neg1_q, neg2_q, neg3_q;
  logic [61:0] p1_d [2];
  logic [61:0] p1_q [2];
  logic [52:0] pa2_d [2];
  logic [52:0] pb2_d [2];
  logic [52:0] pa2_q [2];
  logic [52:0] pb2_q [2];
  logic [34:0] q2_q [2];
  logic [34:0] qe3_d [2];
  logic [34:0] qe3_q [2];
  logic [11:0] ql3_q [2];
  logic signed [31:0] r4_d [2];
  logic [1:0]  neg_d;

  // stage 1: x2 * |r|
  always_comb begin
    logic signed [31:0] r;
    logic [31:0] mag;
    for (int j = 0; j < 2; j++) begin
      r        = (j == 0) ? item_i.ra : item_i.rc;
      neg_d[j] = r[31];
      mag      = r[31] ? 32'(-r) : 32'(r);
      p1_d[j]  = 62'(item_i.x2) * 62'(mag);
    end
  end

  // stage 2: reciprocal partial products of q = p / 2^26
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      pa2_d[j] = 53'(p1_q[j][60:26]) * 53'(MV[j][33:17]);
      pb2_d[j] = 53'(p1_q[j][60:26]) * 53'(MV[j][16:0]);
    end
  end

  // stage 3: quotient estimate, at most one low
  always_comb begin
    logic [70:0] sum;
    for (int j = 0; j < 2; j++) begin
      sum      = {pa2_q[j], 17'b0} + 71'(pb2_q[j]);
      qe3_d[j] = sum[69:35];
    end
  end

  // stage 4: remainder check and horner update
  always_comb begin
    logic [11:0] rem;
    logic [34:0] qt;
    for (int j = 0; j < 2; j++) begin
      rem     = ql3_q[j] - 12'(qe3_q[j][11:0] * 12'(DV[j]));
      qt      = qe3_q[j] + 35'(rem >= 12'(DV[j]));
      r4_d[j] = neg3_q[j] ? (Q30One + 32'(qt)) : (Q30One - 32'(qt));
    end
  end

  // item leaving the cell carries the updated partials
  always_comb begin
    it4_d    = it3_q;
    it4_d.ra = r4_d[0];
    it4_d.rc = r4_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it1_q <= '0;
      it2_q <= '0;
      it3_q <= '0;
      it4_q <= '0;
    end else if (en_i) begin
      it1_q <= item_i;
      it2_q <= it1_q;
      it3_q <= it2_q;
      it4_q <= it4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= neg_d;
      neg2_q <= neg1_q;
      neg3_q <= neg2_q;
      for (int j = 0; j < 2; j++) begin
        p1_q[j]  <= p1_d[j];
        pa2_q[j] <= pa2_d[j];
        pb2_q[j] <= pb2_d[j];
        q2_q[j]  <= p1_q[j][60:26];
        qe3_q[j] <= qe3_d[j];
        ql3_q[j] <= q2_q[j][11:0];
      end
    end
  end

  assign item_o = it4_q;

endmodule

// ----- sv/se2x_tail.sv -----
module se2x_tail (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  se2x_pkg::se2x_item_t item_i,
  output logic                 vld_o,
  output se2x_pkg::se2x_res_t  res_o
);
  import se2x_pkg::*;

  function automatic logic signed [15:0] clamp_q14(input logic signed [36:0] v);
    if (v > 37'sd16384) begin
      return 16'sd16384;
    end else if (v < -37'sd16384) begin
      return -16'sd16384;
    end
    return 16'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -37'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  // stage 1
  logic               v1_q;
  logic signed [62:0] pc1_q;
  logic signed [47:0] ps1_q, pb1_q;
  logic signed [31:0] sa1_q, vx1_q, vy1_q;
  // stage 2
  logic               v2_q;
  logic signed [15:0] c2_q, s2_q;
  logic signed [33:0] bq2_q;
  logic signed [31:0] sa2_q, vx2_q, vy2_q;
  // stage 3
  logic               v3_q;
  logic signed [15:0] c3_q, s3_q;
  logic signed [65:0] m1_q, m2_q, m3_q, m4_q;
  // stage 4
  logic               v4_q;
  se2x_res_t          res4_q;

  logic signed [62:0] pc_d;
  logic signed [47:0] ps_d, pb_d;
  logic signed [62:0] pc_adj;
  logic signed [36:0] cq30, c_rnd, s_rnd;
  logic signed [47:0] bq_rnd;
  logic signed [66:0] sx, sy;
  logic signed [36:0] rx, ry;

  always_comb begin
    pc_d = 63'(signed'({1'b0, item_i.x2})) * 63'(item_i.rc);
    ps_d = 48'(item_i.rot) * 48'(item_i.ra);
    pb_d = 48'(item_i.rot) * 48'(item_i.rc);
  end

  // cos, sin and (1-cos w)/w narrowing
  always_comb begin
    pc_adj = pc1_q + (pc1_q[62] ? 63'sd134217727 : 63'sd0);
    cq30   = 37'(Q30One) - 37'(pc_adj >>> 27);
    c_rnd  = (cq30 + 37'sd32768) >>> 16;
    s_rnd  = 37'((ps1_q + 48'sd268435456) >>> 29);
    bq_rnd = (pb1_q + 48'sd8192) >>> 14;
  end

  // translation sums
  always_comb begin
    sx = 67'(m1_q) - 67'(m2_q);
    sy = 67'(m3_q) + 67'(m4_q);
    rx = 37'((sx + 67'sd536870912) >>> 30);
    ry = 37'((sy + 67'sd536870912) >>> 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= item_i.vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc1_q <= pc_d;
      ps1_q <= ps_d;
      pb1_q <= pb_d;
      sa1_q <= item_i.ra;
      vx1_q <= item_i.vx;
      vy1_q <= item_i.vy;

      c2_q  <= clamp_q14(c_rnd);
      s2_q  <= clamp_q14(s_rnd);
      bq2_q <= 34'(bq_rnd);
      sa2_q <= sa1_q;
      vx2_q <= vx1_q;
      vy2_q <= vy1_q;

      c3_q <= c2_q;
      s3_q <= s2_q;
      m1_q <= 66'(vx2_q) * 66'(sa2_q);
      m2_q <= 66'(vy2_q) * 66'(bq2_q);
      m3_q <= 66'(vx2_q) * 66'(bq2_q);
      m4_q <= 66'(vy2_q) * 66'(sa2_q);

      res4_q.cos_term <= c3_q;
      res4_q.sin_term <= s3_q;
      res4_q.shift_x  <= sat32(rx);
      res4_q.shift_y  <= sat32(ry);
      res4_q.overflow <= (rx != 37'(sat32(rx))) || (ry != 37'(sat32(ry)));
    end
  end

  assign vld_o = v4_q;
  assign res_o = res4_q;

endmodule

// ----- sv/se2_twist_exponential_unit.sv -----
// se2 exponential map of a planar twist
// in_ch_i: one twist per transfer (rotation q3.13, vel_x and vel_y q16.16);
//   rotation beyond plus or minus pi is clamped first
// out_ch_o: one transform per transfer (cos and sin q1.14, shift_x and
//   shift_y q16.16 saturated, overflow when either shift saturated)
// a zero rotation gives a pure translation, no special path needed
// pipeline: 1 input stage, 11 horner cells of 4 stages each, 5 tail
//   and buffer stages
// throughput: one twist per cycle while the output buffer has room; the
//   chain of horner cells is fully pipelined and each cell owns its own multipliers
// a two-entry output buffer decouples the receiver: while one result waits,
//   input is still accepted; the whole chain holds only when both entries
//   are full, and then in_ch_i.ready is low
// reset clears all valid bits and the output buffer; no results are
//   pending after reset
module se2_twist_exponential_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  se2x_in_if.sink    in_ch_i,
  se2x_out_if.source out_ch_o
);
  import se2x_pkg::*;

  // chain advance: output buffer has room
  logic       en;
  logic [1:0] count_q, count_d;
  logic       wr_q, rd_q;
  logic       push, pop;

  se2x_item_t it0_q, it0_d;
  se2x_item_t chain [NumTerms+1];
  logic       tail_vld;
  se2x_res_t  tail_res;
  se2x_res_t  buf_q [2];
  se2x_res_t  rd_res;

  assign en = (count_q != 2'd2);
  assign in_ch_i.ready = en;

  // input stage: clamp rotation, square it, seed both series with one
  always_comb begin
    logic signed [15:0] w;
    logic signed [31:0] sq;
    w = in_ch_i.rotation;
    if (w > RotLimit) begin
      w = RotLimit;
    end else if (w < -RotLimit) begin
      w = -RotLimit;
    end
    sq        = 32'(w) * 32'(w);
    it0_d.vld = in_ch_i.valid;
    it0_d.rot = w;
    it0_d.x2  = sq[29:0];
    it0_d.vx  = in_ch_i.vel_x;
    it0_d.vy  = in_ch_i.vel_y;
    it0_d.ra  = Q30One;
    it0_d.rc  = Q30One;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it0_q <= '0;
    end else if (en) begin
      it0_q <= it0_d;
    end
  end

  assign chain[0] = it0_q;

  // horner cells, highest series term first
  for (genvar i = 0; i < NumTerms; i++) begin : g_cell
    se2x_cell #(
      .K(NumTerms - i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .item_i(chain[i]),
      .item_o(chain[i+1])
    );
  end

  // trig terms and translation
  se2x_tail u_tail (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .item_i(chain[NumTerms]),
    .vld_o (tail_vld),
    .res_o (tail_res)
  );

  // two-entry output buffer
  assign push = tail_vld && en;
  assign pop  = out_ch_o.valid && out_ch_o.ready;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= tail_res;
    end
  end

  assign rd_res            = buf_q[rd_q];
  assign out_ch_o.valid    = (count_q != 2'd0);
  assign out_ch_o.cos_term = rd_res.cos_term;
  assign out_ch_o.sin_term = rd_res.sin_term;
  assign out_ch_o.shift_x  = rd_res.shift_x;
  assign out_ch_o.shift_y  = rd_res.shift_y;
  assign out_ch_o.overflow = rd_res.overflow;

  // buffer never holds more than two results
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output buffer count out of range");

  // a result arriving from the tail always finds room
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !pop) |=> (count_q == 2'd2))
    else $error("result pushed into a full buffer");

  // overflow only with a saturated shift
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && out_ch_o.overflow) |->
      (out_ch_o.shift_x == 32'sh7fff_ffff || out_ch_o.shift_x == 32'sh8000_0000 ||
       out_ch_o.shift_y == 32'sh7fff_ffff || out_ch_o.shift_y == 32'sh8000_0000))
    else $error("overflow without saturated translation");

  // trig outputs stay within plus or minus one
  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid |->
      (out_ch_o.cos_term <= 16'sd16384 && out_ch_o.cos_term >= -16'sd16384 &&
       out_ch_o.sin_term <= 16'sd16384 && out_ch_o.sin_term >= -16'sd16384))
    else $error("trig term out of range");

endmodule

// ----- bench/se2x_twist_checker.sv -----
`timescale 1ns / 100ps

module se2x_twist_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  se2x_in_if.sink    in_mon,
  se2x_out_if.sink   out_mon,
  output int         fail_cnt_o,
  output int         pending_o,
  output int         seen_o,
  output int         ovf_seen_o,
  output int         zero_seen_o
);
  import se2x_pkg::*;

  typedef struct {
    logic signed [15:0] cos_term;
    logic signed [15:0] sin_term;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic               overflow;
  } transform_t;

  transform_t transform_q[$];

  // round to nearest by 2^s, ties toward plus infinity
  function automatic longint round_q(longint v, int s);
    longint t;
    t = v + (longint'(1) << (s - 1));
    return t >>> s;
  endfunction

  // horner nest of sin(w)/w (odd=0) or 2(1-cos w)/w^2 (odd=1) in q2.30
  function automatic longint horner_q30(longint x2, bit odd);
    longint r, a, d;
    r = longint'(1) << 30;
    for (int k = NumTerms; k >= 1; k--) begin
      a = odd ? (2 * k + 1) : (2 * k);
      d = a * (a + 1);
      r = (longint'(1) << 30) - (x2 * r) / (d << 26);
    end
    return r;
  endfunction

  function automatic longint clamp14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic transform_t exp_twist(logic signed [15:0] rot,
                                           logic signed [31:0] vxi,
                                           logic signed [31:0] vyi);
    transform_t t;
    longint w, vx, vy, x2, sa, sc, cq, bq, dx, dy;
    w = rot;
    vx = vxi;
    vy = vyi;
    if (w > RotLimit) w = RotLimit;
    if (w < -RotLimit) w = -RotLimit;
    x2 = w * w;
    sa = horner_q30(x2, 1'b0);
    sc = horner_q30(x2, 1'b1);
    cq = (longint'(1) << 30) - (x2 * sc) / (longint'(2) << 26);
    t.cos_term = 16'(clamp14(round_q(cq, 16)));
    t.sin_term = 16'(clamp14(round_q(w * sa, 29)));
    bq = round_q(w * sc, 14);
    dx = round_q(vx * sa - vy * bq, 30);
    dy = round_q(vx * bq + vy * sa, 30);
    t.overflow = 1'b0;
    if (dx > 64'sd2147483647) begin dx = 64'sd2147483647; t.overflow = 1'b1; end
    if (dx < -64'sd2147483648) begin dx = -64'sd2147483648; t.overflow = 1'b1; end
    if (dy > 64'sd2147483647) begin dy = 64'sd2147483647; t.overflow = 1'b1; end
    if (dy < -64'sd2147483648) begin dy = -64'sd2147483648; t.overflow = 1'b1; end
    t.shift_x = dx[31:0];
    t.shift_y = dy[31:0];
    return t;
  endfunction

  assign pending_o = transform_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    transform_t e;
    if (!rst_ni) begin
      transform_q.delete();
      fail_cnt_o  <= 0;
      seen_o      <= 0;
      ovf_seen_o  <= 0;
      zero_seen_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        transform_q.push_back(exp_twist(in_mon.rotation, in_mon.vel_x, in_mon.vel_y));
        if (in_mon.rotation == 0) zero_seen_o <= zero_seen_o + 1;
      end
      if (out_mon.valid && out_mon.ready) begin
        seen_o <= seen_o + 1;
        if (out_mon.overflow) ovf_seen_o <= ovf_seen_o + 1;
        if (transform_q.size() == 0) begin
          $error("transform transfer with nothing expected");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = transform_q.pop_front();
          if (out_mon.cos_term !== e.cos_term ||
              out_mon.sin_term !== e.sin_term ||
              out_mon.shift_x !== e.shift_x ||
              out_mon.shift_y !== e.shift_y ||
              out_mon.overflow !== e.overflow)
            fail_cnt_o <= fail_cnt_o + 1;
          if (out_mon.cos_term !== e.cos_term)
            $error("cos_term expected %0d got %0d", e.cos_term, out_mon.cos_term);
          if (out_mon.sin_term !== e.sin_term)
            $error("sin_term expected %0d got %0d", e.sin_term, out_mon.sin_term);
          if (out_mon.shift_x !== e.shift_x)
            $error("shift_x expected %0d got %0d", e.shift_x, out_mon.shift_x);
          if (out_mon.shift_y !== e.shift_y)
            $error("shift_y expected %0d got %0d", e.shift_y, out_mon.shift_y);
          if (out_mon.overflow !== e.overflow)
            $error("overflow expected %0b got %0b", e.overflow, out_mon.overflow);
        end
      end
    end
  end

endmodule

// ----- bench/tb_se2_twist_exponential_unit.sv -----
`timescale 1ns / 100ps

module tb_se2_twist_exponential_unit;
  import se2x_pkg::*;

  localparam int Latency   = 50;
  localparam int RandTwists = 1800;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt, pending, seen, ovf_seen, zero_seen;
  bit   drain_mode;   // last part of the run: no idling on either side
  bit   hold_sink;    // long receiver hold-off requested by the stimulus

  se2x_in_if  in_ch();
  se2x_out_if out_ch();

  se2_twist_exponential_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch.sink),
    .out_ch_o(out_ch.source)
  );

  se2x_twist_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch.sink),
    .out_mon    (out_ch.sink),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .seen_o     (seen),
    .ovf_seen_o (ovf_seen),
    .zero_seen_o(zero_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(8 * 400000);
    $display("se2_twist_exponential_unit test failed");
    $finish;
  end

  // random velocity: half moderate, half full-range or near the extremes to drive saturation
  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return 32'($signed($urandom_range(0, 131072 * 64)) - 131072 * 32);
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 255)
                                           : 32'h8000_0000 + $urandom_range(0, 255);
    endcase
  endfunction

  // random rotation covering the clamp zone and the full 16-bit range
  function automatic logic [15:0] rand_rot();
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 64)) - 32);
      2: return $urandom_range(0, 1) ? 16'(25736 - $urandom_range(0, 40))
                                     : 16'(-25736 + $urandom_range(0, 40));
      default: return 16'($signed($urandom_range(0, 2 * 25736)) - 25736);
    endcase
  endfunction

  // one twist transfer, with a random idle burst before it unless draining
  task automatic send_twist(input logic [15:0] rot, input logic [31:0] vx,
                            input logic [31:0] vy);
    int gap;
    if (!drain_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.rotation <= rot;
    in_ch.vel_x    <= vx;
    in_ch.vel_y    <= vy;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // receiver: bursts of stall, plus the long hold-off on request
  initial begin
    int burst;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        @(posedge clk_i);
      end else if (!drain_mode && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 18);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) begin
          @(posedge clk_i);
          if (hold_sink) break;
        end
      end
    end
  end

  initial begin
    logic [15:0] dir_rot[13];
    int n;
    dir_rot = '{16'h0000, 16'd1, 16'hffff, 16'd25736, -16'sd25736, 16'd25737,
                -16'sd25737, 16'h7fff, 16'h8000, 16'd12868, -16'sd12868,
                16'd8192, 16'h5555};
    drain_mode     = 1'b0;
    hold_sink      = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.rotation <= '0;
    in_ch.vel_x    <= '0;
    in_ch.vel_y    <= '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero rotation pure translation, clamp edges, full-scale velocities
    send_twist(16'h0000, 32'h7fff_ffff, 32'h8000_0000);
    send_twist(16'h0000, 32'h0001_0000, 32'hffff_0000);
    foreach (dir_rot[i]) send_twist(dir_rot[i], 32'h0001_0000, 32'h0002_8000);
    send_twist(16'd25736, 32'h7fff_ffff, 32'h7fff_ffff);
    send_twist(-16'sd25736, 32'h8000_0000, 32'h8000_0000);
    send_twist(16'd12868, 32'h7fff_ffff, 32'h8000_0000);
    send_twist(16'd100, 32'hffff_ffff, 32'hffff_ffff);
    send_twist(16'h5a5a, 32'haaaa_aaaa, 32'h5555_5555);
    send_twist(16'ha5a5, 32'h5555_5555, 32'haaaa_aaaa);

    // sender pause until everything is back
    quiesce();

    // receiver holds off while the sender keeps offering, filling the pipe
    hold_sink = 1'b1;
    fork
      begin
        repeat (Latency * 3) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      begin
        n = 0;
        while (hold_sink && n < 200) begin
          send_twist(rand_rot(), rand_vel(), rand_vel());
          n++;
        end
      end
    join

    for (int i = 0; i < RandTwists; i++) begin
      if (i == RandTwists - 200) drain_mode = 1'b1;
      send_twist(rand_rot(), rand_vel(), rand_vel());
    end
    in_ch.valid <= 1'b0;

    n = 0;
    while (pending != 0 && n < 100000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (Latency + 10) @(posedge clk_i);

    $display("covered %0d transforms, %0d saturated, %0d with zero rotation",
             seen, ovf_seen, zero_seen);
    $display("directed edge twists, a long output hold-off and a drained tail");
    if (fail_cnt == 0 && pending == 0) begin
      $display("se2_twist_exponential_unit test passed");
    end else begin
      if (pending != 0) $error("%0d transforms never arrived", pending);
      $display("se2_twist_exponential_unit test failed");
    end
    $finish;
  end

endmodule
